FILE: hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package skt_pkg;

    localparam int DEPTH_DEF     = 128;
    localparam int KEY_CHARS_DEF = 24;
    localparam int KEY_W         = 192;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_high;
        logic [63:0] key_mid;
        logic [63:0] key_low;
        logic [6:0]  rank;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  position;
        logic [7:0]  entries;
        logic [63:0] out_high;
        logic [63:0] out_mid;
        logic [63:0] out_low;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RD_WAIT
    } state_t;

    typedef enum logic [1:0] {
        RA_IDX_M1,
        RA_IDX,
        RA_IDX_P1,
        RA_RANK
    } rd_src_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_IDX,
        POS_RANK,
        POS_MARK
    } pos_src_t;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        rd_src_t  rd_src;
        logic     wr_en;
        logic     wr_key;
        idx_op_t  idx_op;
        cnt_op_t  cnt_op;
        logic     res_en;
        logic [1:0] res_status;
        pos_src_t pos_src;
        logic     res_data;
        logic     mark;
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       idx_zero;
        logic       idx_end;
        logic       idx_last;
        logic       gt;
        logic       eq;
        logic       rank_bad;
    } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/skt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module skt_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/skt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module skt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire skt_pkg::sts_t sts,
    output logic               busy,
    output skt_pkg::ctl_t      ctl
);
    import skt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_INSERT: state_next = sts.full ? S_IDLE : S_INS_RD;
                    CMD_DELETE: state_next = S_DEL_RD;
                    CMD_READ:   state_next = sts.rank_bad ? S_IDLE : S_RD_WAIT;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_INS_RD:  state_next = sts.idx_zero ? S_INS_PUT : S_INS_CMP;
            S_INS_CMP: state_next = sts.gt ? S_INS_RD : S_INS_PUT;
            S_INS_PUT: state_next = S_IDLE;
            S_DEL_RD:  state_next = sts.idx_end ? S_IDLE : S_DEL_CMP;
            S_DEL_CMP: state_next = sts.eq ? S_SH_RD : S_DEL_RD;
            S_SH_RD:   state_next = sts.idx_last ? S_IDLE : S_SH_WR;
            S_SH_WR:   state_next = S_SH_RD;
            S_RD_WAIT: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        ctl.rd_src     = RA_IDX;
        ctl.idx_op     = IDX_HOLD;
        ctl.cnt_op     = CNT_HOLD;
        ctl.pos_src    = POS_ZERO;
        ctl.res_status = ST_OK;
        busy           = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                ctl.load = start;
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_INSERT:
                    begin
                        if (sts.full)
                        begin
                            ctl.res_en     = 1'b1;
                            ctl.res_status = ST_FULL;
                        end
                    end
                    CMD_DELETE:
                    begin
                    end
                    CMD_READ:
                    begin
                        if (sts.rank_bad)
                        begin
                            ctl.res_en     = 1'b1;
                            ctl.res_status = ST_RANGE;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_src = RA_RANK;
                        end
                    end
                    default:
                    begin
                        ctl.res_en = 1'b1;
                    end
                endcase
            end
            S_INS_RD:
            begin
                ctl.rd_en  = !sts.idx_zero;
                ctl.rd_src = RA_IDX_M1;
            end
            S_INS_CMP:
            begin
                if (sts.gt)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.idx_op = IDX_DEC;
                end
            end
            S_INS_PUT:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_key  = 1'b1;
                ctl.cnt_op  = CNT_INC;
                ctl.res_en  = 1'b1;
                ctl.pos_src = POS_IDX;
            end
            S_DEL_RD:
            begin
                if (sts.idx_end)
                begin
                    ctl.res_en     = 1'b1;
                    ctl.res_status = ST_NOT_FOUND;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                end
            end
            S_DEL_CMP:
            begin
                if (sts.eq)
                begin
                    ctl.mark = 1'b1;
                end
                else
                begin
                    ctl.idx_op = IDX_INC;
                end
            end
            S_SH_RD:
            begin
                if (sts.idx_last)
                begin
                    ctl.cnt_op  = CNT_DEC;
                    ctl.res_en  = 1'b1;
                    ctl.pos_src = POS_MARK;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_src = RA_IDX_P1;
                end
            end
            S_SH_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.idx_op = IDX_INC;
            end
            S_RD_WAIT:
            begin
                ctl.res_en   = 1'b1;
                ctl.pos_src  = POS_RANK;
                ctl.res_data = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/skt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module skt_dpath #(
    parameter int DEPTH     = skt_pkg::DEPTH_DEF,
    parameter int KEY_CHARS = skt_pkg::KEY_CHARS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire skt_pkg::in_word_t request,
    input  wire skt_pkg::ctl_t     ctl,
    output skt_pkg::sts_t          sts,
    output skt_pkg::out_word_t     result,
    output logic                   done
);
    import skt_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_CHARS);

    logic [KEY_W-1:0] key_reg;
    logic [1:0]       cmd_reg;
    logic [6:0]       rank_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    idx_next;
    logic [CW-1:0]    mark_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    out_word_t        result_reg;
    logic             done_reg;

    logic [KEY_W-1:0] rd_data;
    logic [KEY_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    idx_m1;
    logic [CW-1:0]    idx_p1;
    logic [6:0]       pos_val;

    assign idx_m1  = idx_reg - CW'(1);
    assign idx_p1  = idx_reg + CW'(1);
    assign wr_data = ctl.wr_key ? key_reg : rd_data;

    always_comb
    begin
        case (ctl.rd_src)
            RA_IDX_M1: rd_addr = idx_m1[AW-1:0];
            RA_IDX_P1: rd_addr = idx_p1[AW-1:0];
            RA_RANK:   rd_addr = AW'(rank_reg);
            default:   rd_addr = idx_reg[AW-1:0];
        endcase
    end

    skt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        sts.cmd      = cmd_reg;
        sts.full     = (count_reg >= CW'(DEPTH));
        sts.idx_zero = (idx_reg == '0);
        sts.idx_end  = (idx_reg >= count_reg);
        sts.idx_last = (idx_p1 >= count_reg);
        sts.gt       = (rd_data > key_reg);
        sts.eq       = (rd_data == key_reg);
        sts.rank_bad = ({25'd0, rank_reg} >= 32'(count_reg));
    end

    always_comb
    begin
        case (ctl.idx_op)
            IDX_INC: idx_next = idx_p1;
            IDX_DEC: idx_next = idx_m1;
            default: idx_next = idx_reg;
        endcase
        if (ctl.load)
        begin
            idx_next = (request.cmd == CMD_INSERT) ? count_reg : '0;
        end
        case (ctl.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
        case (ctl.pos_src)
            POS_IDX:  pos_val = 7'(idx_reg);
            POS_RANK: pos_val = rank_reg;
            POS_MARK: pos_val = 7'(mark_reg);
            default:  pos_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= ctl.res_en;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (ctl.mark)
        begin
            mark_reg <= idx_reg;
        end
        if (ctl.load)
        begin
            key_reg  <= {request.key_high, request.key_mid, request.key_low} & KEY_MASK;
            cmd_reg  <= request.cmd;
            rank_reg <= request.rank;
        end
        if (ctl.res_en)
        begin
            result_reg.status   <= ctl.res_status;
            result_reg.position <= pos_val;
            result_reg.entries  <= 8'(count_next);
            result_reg.out_high <= ctl.res_data ? rd_data[191:128] : 64'd0;
            result_reg.out_mid  <= ctl.res_data ? rd_data[127:64] : 64'd0;
            result_reg.out_low  <= ctl.res_data ? rd_data[63:0] : 64'd0;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/sorted_key_table_insert_delete_core.sv
// Sorted key table: holds up to DEPTH keys of up to KEY_CHARS characters in
// ascending order, each key compared as one 192-bit big-endian number.
// A command word is taken on request at a rising edge where start is high and
// busy is low; busy then stays high until the command has finished.
// Every command returns one result word on result, marked by done for exactly
// one cycle; the receiver cannot stall, so it must take the word in that cycle.
// Insert walks down from the top entry, moving each larger key up one place,
// then writes the new key into the gap that is left.
// Delete scans up from the bottom entry, reading then comparing each key; on a
// match it moves the later keys down one place, reading then writing each key.
// Read fetches the entry at the given rank; a full-table insert, bad rank or
// unused command returns its result word straight from the dispatch state.
// The key memory has a single write port and a single read port.
// Reset empties the table at once; no clearing pass is needed because entries
// above the fill count are never read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_table_insert_delete_core #(
    parameter int DEPTH     = skt_pkg::DEPTH_DEF,
    parameter int KEY_CHARS = skt_pkg::KEY_CHARS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire skt_pkg::in_word_t request,
    output logic                   busy,
    output logic                   done,
    output skt_pkg::out_word_t     result
);
    import skt_pkg::*;

    ctl_t ctl;
    sts_t sts;

    skt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .ctl   (ctl)
    );

    skt_dpath #(
        .DEPTH     (DEPTH),
        .KEY_CHARS (KEY_CHARS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int STALL_LIMIT = 5000;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_word_t  request;
    logic      busy;
    logic      done;
    out_word_t result;

    sorted_key_table_insert_delete_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .done(done),
        .result(result)
    );

    logic [191:0] table_keys [TABLE_DEPTH];
    int           key_count;
    out_word_t    awaited_words [$];
    in_word_t     pending_words [$];
    logic [191:0] used_keys [$];
    int           errors;
    int           idle_cycles;
    int           gap_left;
    bit           feed_done;
    bit           drain_hold;
    bit           in_flight;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_word_t predict_table(in_word_t w);
        out_word_t    r;
        logic [191:0] k;
        int           p;
        r = '0;
        k = {w.key_high, w.key_mid, w.key_low};
        if (w.cmd == CMD_INSERT)
        begin
            if (key_count >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                p = 0;
                while (p < key_count && table_keys[p] <= k)
                    p++;
                for (int q = key_count; q > p; q--)
                    table_keys[q] = table_keys[q - 1];
                table_keys[p] = k;
                key_count++;
                r.position = p[6:0];
            end
        end
        else if (w.cmd == CMD_DELETE)
        begin
            p = 0;
            while (p < key_count && table_keys[p] != k)
                p++;
            if (p == key_count)
                r.status = ST_NOT_FOUND;
            else
            begin
                for (int q = p; q + 1 < key_count; q++)
                    table_keys[q] = table_keys[q + 1];
                key_count--;
                r.position = p[6:0];
            end
        end
        else if (w.cmd == CMD_READ)
        begin
            if (int'(w.rank) >= key_count)
                r.status = ST_RANGE;
            else
            begin
                {r.out_high, r.out_mid, r.out_low} = table_keys[w.rank];
                r.position = w.rank;
            end
        end
        r.entries = key_count[7:0];
        return r;
    endfunction

    function automatic logic [191:0] random_key();
        logic [191:0] k;
        int           sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && used_keys.size() > 0)
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        else if (sel < 7)
            k = {8'($urandom_range(0, 3)), 184'd0};
        else
            k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (used_keys.size() < 64)
            used_keys.push_back(k);
        return k;
    endfunction

    task automatic add_word(logic [1:0] c, logic [191:0] k, logic [6:0] rk);
        in_word_t w;
        w.cmd = c;
        {w.key_high, w.key_mid, w.key_low} = k;
        w.rank = rk;
        pending_words.push_back(w);
    endtask

    in_word_t drain_marker;

    initial
    begin
        int c;
        drain_marker = '1;
        add_word(CMD_READ, '0, 7'd0);
        add_word(CMD_DELETE, '0, 7'd0);
        add_word(CMD_INSERT, '1, 7'd0);
        add_word(CMD_INSERT, '0, 7'd0);
        add_word(CMD_INSERT, '0, 7'd0);
        add_word(CMD_INSERT, {8'h41, 56'h0, 64'h0, 64'h00FF}, 7'd0);
        add_word(CMD_INSERT, {8'h41, 184'h0}, 7'd0);
        add_word(CMD_READ, '0, 7'd0);
        add_word(CMD_READ, '0, 7'd4);
        add_word(CMD_READ, '0, 7'd5);
        add_word(CMD_READ, '0, 7'd127);
        add_word(2'd3, '1, 7'h7E);
        add_word(CMD_DELETE, '0, 7'd0);
        add_word(CMD_DELETE, {8'h42, 184'h0}, 7'd0);
        add_word(CMD_DELETE, '1, 7'd0);
        add_word(CMD_READ, '0, 7'd1);
        for (int i = 0; i < 130; i++)
            add_word(CMD_INSERT, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom},
                     7'd0);
        add_word(CMD_READ, '0, 7'd127);
        pending_words.push_back(drain_marker);
        for (int i = 0; i < 128; i++)
            add_word(CMD_DELETE, '0, 7'd0);
        for (int i = 0; i < 128; i++)
            add_word(CMD_READ, '0, 7'(i));
        for (int i = 0; i < 850; i++)
        begin
            c = $urandom_range(0, 19);
            if (c < 8)
                add_word(CMD_INSERT, random_key(), 7'($urandom));
            else if (c < 14)
                add_word(CMD_DELETE, random_key(), 7'($urandom));
            else if (c < 19)
                add_word(CMD_READ, random_key(), 7'($urandom_range(0, 40)));
            else
                add_word(2'd3, random_key(), 7'($urandom));
        end
        feed_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            gap_left <= 0;
            in_flight <= 1'b0;
            drain_hold <= 1'b0;
        end
        else if (start && !busy)
        begin
            start <= 1'b0;
            awaited_words.push_back(predict_table(request));
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                        : $urandom_range(0, 2);
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_words.size() > 0 && pending_words[0] === drain_marker)
            begin
                if (awaited_words.size() == 0)
                    void'(pending_words.pop_front());
            end
            else if (pending_words.size() > 0)
            begin
                request <= pending_words.pop_front();
                start <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_words.size() == 0)
            begin
                $display("%0t: result word with none expected: %h", $time, result);
                errors++;
            end
            else
            begin
                out_word_t e;
                e = awaited_words.pop_front();
                if (result.status !== e.status || result.position !== e.position ||
                    result.entries !== e.entries || result.out_high !== e.out_high ||
                    result.out_mid !== e.out_mid || result.out_low !== e.out_low)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, result);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            if (feed_done && pending_words.size() == 0 && !start &&
                awaited_words.size() == 0)
            begin
                repeat (600) @(posedge clk);
                if (errors == 0 && awaited_words.size() == 0 && !done)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end
        end
    end
endmodule

FILE: files.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_ram.sv
hw/rtl/skt_ctrl.sv
hw/rtl/skt_dpath.sv
hw/rtl/sorted_key_table_insert_delete_core.sv
tb/tb.sv
